// File: design/cfct_pkg.sv
// Shared types and constants for the client flow counter table.
package cfct_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned StatW  = 3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [StatW-1:0] ST_HIT        = 3'd0;
  localparam logic [StatW-1:0] ST_NEW        = 3'd1;
  localparam logic [StatW-1:0] ST_FULL       = 3'd2;
  localparam logic [StatW-1:0] ST_CLOSED     = 3'd3;
  localparam logic [StatW-1:0] ST_CLOSE_MISS = 3'd4;

  localparam logic FUNC_MSG   = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // Lookup token that walks down the row of entry cells.
  typedef struct packed {
    logic              vld;
    logic              func;
    logic [AddrW-1:0]  addr;
    logic [PortW-1:0]  port;
    logic              hit;
    logic              free_seen;
    logic [CountW-1:0] count;
  } tok_t;

  // Claim of the tentatively chosen free entry, sent to all cells.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [PortW-1:0] port;
  } claim_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } ctl_state_t;

endpackage

// File: design/client_flow_counter_table.sv
// Top level of the client flow counter table: cell row, control and result register.
//
// Usage: each input item carries func (0 message, 1 close), src_addr and
// src_port. Every item yields exactly one result item with msg_count and
// status (0 hit, 1 new entry, 2 table full, 3 closed, 4 close miss).
// Both channels use valid/stall; an item moves on an edge with valid high
// and stall low.
// An accepted item becomes a token that walks down a row of ENTRIES entry
// cells, one cell per cycle. A message that misses claims the first free
// cell it passed when the token leaves the row. As the token leaves, its
// result is loaded into the output register, or held inside if the
// receiver stalls. A new item is accepted only after the token has left
// the row, so only one item is in the row at a time.
// in_stall stays high while a token is in the row. If the receiver stalls,
// the result waits in the output register and one more finished result is
// held inside; a further item is not accepted until that one moves out.
// Reset (synchronous, rst_n low) frees every entry and clears the counters
// in the same cycle; no clearing pass is needed.
module client_flow_counter_table
  import cfct_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [AddrW-1:0]  in_src_addr,
  input  logic [PortW-1:0]  in_src_port,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CountW-1:0] out_msg_count,
  output logic [StatW-1:0]  out_status
);

  ctl_state_t state_r, state_nxt;

  tok_t   tok [ENTRIES+1];
  tok_t   head_r;
  claim_t claim;
  tok_t   tok_end;

  logic              in_acc;
  logic              out_free;
  logic              load_out;
  logic              load_hold;
  logic [CountW-1:0] res_count;
  logic [StatW-1:0]  res_status;
  logic [CountW-1:0] hold_count_r;
  logic [StatW-1:0]  hold_status_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CountW-1:0] out_count_r;
  logic [StatW-1:0]  out_status_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign tok_end  = tok[ENTRIES];

  // Token entering the row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r.vld       <= in_acc;
      head_r.func      <= in_func;
      head_r.addr      <= in_src_addr;
      head_r.port      <= in_src_port;
      head_r.hit       <= 1'b0;
      head_r.free_seen <= 1'b0;
      head_r.count     <= '0;
    end
  end

  assign tok[0] = head_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cfct_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok[i]),
      .claim_i (claim),
      .tok_o   (tok[i+1])
    );
  end

  // Result of the item whose token leaves the row this cycle.
  always_comb begin
    res_count  = '0;
    res_status = ST_CLOSE_MISS;
    if (tok_end.func == FUNC_CLOSE) begin
      res_status = tok_end.hit ? ST_CLOSED : ST_CLOSE_MISS;
    end else if (tok_end.hit) begin
      res_status = ST_HIT;
      res_count  = tok_end.count;
    end else if (tok_end.free_seen) begin
      res_status = ST_NEW;
      res_count  = {{(CountW-1){1'b0}}, 1'b1};
    end else begin
      res_status = ST_FULL;
    end
  end

  assign claim.en   = tok_end.vld && (tok_end.func == FUNC_MSG) &&
                      !tok_end.hit && tok_end.free_seen;
  assign claim.addr = tok_end.addr;
  assign claim.port = tok_end.port;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (tok_end.vld) begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    load_out  = 1'b0;
    load_hold = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_RUN: begin
        load_out  = tok_end.vld && out_free;
        load_hold = tok_end.vld && !out_free;
      end
      S_HOLD: load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hold) begin
      hold_count_r  <= res_count;
      hold_status_r <= res_status;
    end
    if (load_out) begin
      out_count_r  <= (state_r == S_HOLD) ? hold_count_r : res_count;
      out_status_r <= (state_r == S_HOLD) ? hold_status_r : res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_msg_count = out_count_r;
  assign out_status    = out_status_r;

endmodule

// File: design/cfct_cell.sv
// One table entry: key compare, counter update and free-entry candidate flag.
module cfct_cell
  import cfct_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  tok_t   tok_i,
  input  claim_t claim_i,
  output tok_t   tok_o
);

  logic              valid_r, valid_nxt;
  logic              cand_r, cand_nxt;
  logic [AddrW-1:0]  addr_r, addr_nxt;
  logic [PortW-1:0]  port_r, port_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  tok_t              tok_r, tok_nxt;

  logic              match;
  logic [CountW-1:0] count_inc;

  assign match = tok_i.vld && !tok_i.hit && valid_r &&
                 (addr_r == tok_i.addr) && (port_r == tok_i.port);
  assign count_inc = (count_r == CountMax) ? CountMax : count_r + 1'b1;

  always_comb begin
    valid_nxt = valid_r;
    cand_nxt  = cand_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    count_nxt = count_r;
    tok_nxt   = tok_i;
    if (tok_i.vld) begin
      // The first free entry seen by this item becomes the claim candidate.
      cand_nxt = !valid_r && !tok_i.free_seen;
      if (!valid_r) begin
        tok_nxt.free_seen = 1'b1;
      end
    end
    if (match) begin
      tok_nxt.hit = 1'b1;
      if (tok_i.func == FUNC_CLOSE) begin
        valid_nxt     = 1'b0;
        count_nxt     = '0;
        tok_nxt.count = '0;
      end else begin
        count_nxt     = count_inc;
        tok_nxt.count = count_inc;
      end
    end
    if (claim_i.en && cand_r) begin
      valid_nxt = 1'b1;
      addr_nxt  = claim_i.addr;
      port_nxt  = claim_i.port;
      count_nxt = {{(CountW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      count_r <= '0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
      count_r <= count_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    port_r <= port_nxt;
  end

  assign tok_o = tok_r;

endmodule

// File: design/cfct_checker.sv
// Port-level checks for the client flow counter table, bound to the top level.
module cfct_checker
  import cfct_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CountW-1:0] out_msg_count,
  input logic [StatW-1:0]  out_status
);

  // A result held back by the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_msg_count) && $stable(out_status))
    else $error("stalled result changed");

  // Only one item is in the lookup row at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a lookup is running");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_HIT || out_status == ST_NEW ||
                  out_status == ST_FULL || out_status == ST_CLOSED ||
                  out_status == ST_CLOSE_MISS)
    else $error("undefined status code");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_CLOSED ||
                  out_status == ST_CLOSE_MISS) |-> out_msg_count == '0)
    else $error("nonzero count on a status that carries none");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEW |-> out_msg_count == 32'd1)
    else $error("new entry must report a count of one");

endmodule

bind client_flow_counter_table cfct_checker u_cfct_checker (.*);
